@@ rtl/wlan_capture_prefilter_macros.svh @@
// Assertion macros used by the capture prefilter checker.
`ifndef WLAN_CAPTURE_PREFILTER_MACROS_SVH
`define WLAN_CAPTURE_PREFILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define WCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define WCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wcp_pkg.sv @@
// Types, codes and helpers of the capture prefilter.
package wcp_pkg;

  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 12;
  localparam int ADDR_BYTES = 6;

  // Verdict codes
  localparam logic [2:0] VERDICT_KEPT    = 3'd0;
  localparam logic [2:0] VERDICT_BAD     = 3'd1;
  localparam logic [2:0] VERDICT_SESSION = 3'd2;
  localparam logic [2:0] VERDICT_ADDR    = 3'd3;
  localparam logic [2:0] VERDICT_SHORT   = 3'd4;

  // Register indexes
  localparam logic [2:0] CFG_KEEP_BAD       = 3'd0;
  localparam logic [2:0] CFG_KEEP_FCS       = 3'd1;
  localparam logic [2:0] CFG_SESSION_FILTER = 3'd2;
  localparam logic [2:0] CFG_GROUP_LEN      = 3'd3;
  localparam logic [2:0] CFG_GROUP_ADDR     = 3'd4;
  localparam logic [2:0] CFG_INTEREST_LEN   = 3'd5;
  localparam logic [2:0] CFG_INTEREST_ADDR  = 3'd6;

  // Frame control codes
  localparam logic [1:0] FTYPE_MGMT     = 2'd0;
  localparam logic [1:0] FTYPE_DATA     = 2'd2;
  localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
  localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
  localparam logic [3:0] SUB_BEACON     = 4'd8;
  localparam int         SUB_DATA_BIT   = 2;

  // Match length codes
  localparam logic [2:0] GLEN_OFF  = 3'd0;
  localparam logic [2:0] GLEN_ANY  = 3'd1;
  localparam logic [2:0] ILEN_OFF  = 3'd0;
  localparam logic [2:0] ILEN_OUI  = 3'd3;
  localparam logic [2:0] ILEN_FULL = 3'd6;

  // Group bit of the first address byte
  localparam int GROUP_BIT = ADDR_W - 8;

  localparam logic [LEN_W-1:0] FCS_BYTES = 12'd4;

  typedef struct packed {
    logic [1:0]        frame_type;
    logic              rx_error;
    logic [3:0]        frame_subtype;
    logic              to_ds;
    logic              from_ds;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [ADDR_W-1:0] addr3;
    logic [ADDR_W-1:0] addr4;
    logic [LEN_W-1:0]  signal_length;
  } wcp_item_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic [LEN_W-1:0] cap_len;
    logic [LEN_W-1:0] pkt_len;
  } wcp_result_t;

  typedef struct packed {
    logic [2:0]        group_match_len;
    logic [ADDR_W-1:0] group_match_addr;
    logic [2:0]        interest_len;
    logic [ADDR_W-1:0] interest_addr;
  } wcp_match_cfg_t;

  // Per-byte equality; bit ADDR_BYTES-1 is the first byte (top bits)
  function automatic logic [ADDR_BYTES-1:0] byte_eq(input logic [ADDR_W-1:0] a,
                                                    input logic [ADDR_W-1:0] b);
    logic [ADDR_BYTES-1:0] eq;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      eq[i] = (a[8*i +: 8] == b[8*i +: 8]);
    end
    return eq;
  endfunction

  // Leading nbytes all equal; lengths past six saturate to the full address
  function automatic logic prefix_hit(input logic [ADDR_BYTES-1:0] eq,
                                      input logic [2:0] nbytes);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      if ((int'(nbytes) > i) && !eq[ADDR_BYTES-1-i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

@@ rtl/wlan_capture_prefilter.sv @@
// Top level of the 802.11 capture prefilter.
//
// Usage: drive one frame header word on item and raise start; the word is
// taken at each rising edge where start is high and busy is low. busy is
// high during reset and in the first cycle after it, and low from then on,
// so a word can be taken every cycle.
// Each word yields one result word on result, marked by result_valid for a
// single cycle; the receiver takes it at that cycle's closing edge and
// cannot hold it off.
// Pipeline: result_valid and result are registered through three register
// stages (byte compares and FCS subtract, prefix reduction and capture clamp,
// verdict priority into the output register).
// Throughput: one word per cycle, sustained.
// Configuration: registers are written through cfg_valid/cfg_ready with
// cfg_index selecting the register; write only while no word is in flight.
// Indexes past the last register are taken and ignored.
// Reset (rst, synchronous): configuration registers and valid bits clear to
// zero, busy is set, the pipeline empties and no result is pending.
module wlan_capture_prefilter
  import wcp_pkg::*;
#(
  parameter int MAX_CAPTURE = 2048
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wcp_item_t         item,
  output logic              result_valid,
  output wcp_result_t       result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam logic [LEN_W-1:0] MAX_CAP = LEN_W'(MAX_CAPTURE);

  // Configuration registers
  logic           keep_bad;
  logic           keep_fcs;
  logic           session_filter;
  wcp_match_cfg_t match_cfg;

  // Stage one
  logic             v1;
  logic             bad1;
  logic             sess1;
  logic             short1;
  logic [LEN_W-1:0] plen1;

  // Stage two
  logic             v2;
  logic             bad2;
  logic             sess2;
  logic             short2;
  logic [LEN_W-1:0] plen2;
  logic [LEN_W-1:0] clen2;

  logic        accept;
  logic        sess_drop;
  logic        addr_drop2;
  wcp_result_t result_next;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Hold busy for the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_bad       <= 1'b0;
      keep_fcs       <= 1'b0;
      session_filter <= 1'b0;
      match_cfg      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEEP_BAD:       keep_bad                   <= cfg_data[0];
        CFG_KEEP_FCS:       keep_fcs                   <= cfg_data[0];
        CFG_SESSION_FILTER: session_filter             <= cfg_data[0];
        CFG_GROUP_LEN:      match_cfg.group_match_len  <= cfg_data[2:0];
        CFG_GROUP_ADDR:     match_cfg.group_match_addr <= cfg_data;
        CFG_INTEREST_LEN:   match_cfg.interest_len     <= cfg_data[2:0];
        CFG_INTEREST_ADDR:  match_cfg.interest_addr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Session filter: beacons, probes, and data subtypes with bit 2 set
  always_comb begin
    sess_drop = 1'b0;
    if (item.frame_type == FTYPE_MGMT) begin
      case (item.frame_subtype)
        SUB_BEACON, SUB_PROBE_REQ, SUB_PROBE_RESP: sess_drop = 1'b1;
        default: sess_drop = 1'b0;
      endcase
    end else if (item.frame_type == FTYPE_DATA) begin
      sess_drop = item.frame_subtype[SUB_DATA_BIT];
    end
    sess_drop = sess_drop && session_filter;
  end

  // Address filter runs alongside stages one and two
  wcp_addr_match u_addr_match (
    .clk       (clk),
    .cfg       (match_cfg),
    .item      (item),
    .addr_drop (addr_drop2)
  );

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= accept;
      v2           <= v1;
      result_valid <= v2;
    end
  end

  // Stage one: error and session checks, strip the FCS unless keep_fcs is set
  always_ff @(posedge clk) begin
    bad1  <= item.rx_error && !keep_bad;
    sess1 <= sess_drop;
    if (keep_fcs) begin
      short1 <= (item.signal_length == '0);
      plen1  <= item.signal_length;
    end else begin
      short1 <= (item.signal_length <= FCS_BYTES);
      plen1  <= item.signal_length - FCS_BYTES;
    end
  end

  // Stage two: clamp the capture length
  always_ff @(posedge clk) begin
    bad2   <= bad1;
    sess2  <= sess1;
    short2 <= short1;
    plen2  <= plen1;
    clen2  <= (plen1 > MAX_CAP) ? MAX_CAP : plen1;
  end

  // Pick the first failing check; zero lengths unless kept
  always_comb begin
    result_next = '0;
    if (bad2) begin
      result_next.verdict = VERDICT_BAD;
    end else if (sess2) begin
      result_next.verdict = VERDICT_SESSION;
    end else if (addr_drop2) begin
      result_next.verdict = VERDICT_ADDR;
    end else if (short2) begin
      result_next.verdict = VERDICT_SHORT;
    end else begin
      result_next.verdict = VERDICT_KEPT;
      result_next.cap_len = clen2;
      result_next.pkt_len = plen2;
    end
  end

  // Stage three: output register
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ rtl/wcp_addr_match.sv @@
// Two-stage address filter: byte compares, then prefix and DS-bit reduction.
module wcp_addr_match
  import wcp_pkg::*;
(
  input  logic           clk,
  input  wcp_match_cfg_t cfg,
  input  wcp_item_t      item,
  output logic           addr_drop
);

  logic [ADDR_BYTES-1:0] g_eq;
  logic                  g_bit;
  logic [ADDR_BYTES-1:0] i_eq1;
  logic [ADDR_BYTES-1:0] i_eq2;
  logic [ADDR_BYTES-1:0] i_eq3;
  logic [ADDR_BYTES-1:0] i_eq4;
  logic                  to_ds1;
  logic                  from_ds1;

  logic [ADDR_W-1:0] gaddr;
  logic              group_keep;
  logic              interest_hit;
  logic              interest_on;
  logic              addr_drop_next;

  // Pick the group address: addr3 toward the DS, addr1 otherwise
  assign gaddr = item.to_ds ? item.addr3 : item.addr1;

  // Stage one: register byte-wise compares
  always_ff @(posedge clk) begin
    g_eq     <= byte_eq(gaddr, cfg.group_match_addr);
    g_bit    <= gaddr[GROUP_BIT];
    i_eq1    <= byte_eq(item.addr1, cfg.interest_addr);
    i_eq2    <= byte_eq(item.addr2, cfg.interest_addr);
    i_eq3    <= byte_eq(item.addr3, cfg.interest_addr);
    i_eq4    <= byte_eq(item.addr4, cfg.interest_addr);
    to_ds1   <= item.to_ds;
    from_ds1 <= item.from_ds;
  end

  // Reduce compares to a drop decision
  always_comb begin
    if (cfg.group_match_len == GLEN_ANY) begin
      group_keep = g_bit;
    end else if (cfg.group_match_len != GLEN_OFF) begin
      group_keep = prefix_hit(g_eq, cfg.group_match_len);
    end else begin
      group_keep = 1'b0;
    end
    interest_hit = (!to_ds1 && prefix_hit(i_eq1, cfg.interest_len))
                || (!from_ds1 && prefix_hit(i_eq2, cfg.interest_len))
                || ((to_ds1 || from_ds1) && prefix_hit(i_eq3, cfg.interest_len))
                || (to_ds1 && from_ds1 && prefix_hit(i_eq4, cfg.interest_len));
    interest_on = (cfg.interest_len == ILEN_OUI) || (cfg.interest_len == ILEN_FULL);
    addr_drop_next = (cfg.interest_len != ILEN_OFF) && !group_keep
                  && interest_on && !interest_hit;
  end

  // Stage two: hold the decision
  always_ff @(posedge clk) begin
    addr_drop <= addr_drop_next;
  end

endmodule

@@ rtl/wcp_checker.sv @@
// Port-level checker for the capture prefilter and its bind.
`include "wlan_capture_prefilter_macros.svh"

module wcp_checker
  import wcp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input wcp_result_t result
);

  `WCP_ASSERT_IMP(a_no_phantom, result_valid, $past(start && !busy, 3),
                  "result without a word taken three cycles before")
  `WCP_ASSERT_IMP(a_no_loss,
                  $past(start && !busy, 3) && !$past(rst, 1) && !$past(rst, 2)
                  && !$past(rst, 3),
                  result_valid, "word taken but no result three cycles later")
  `WCP_ASSERT_IMP(a_drop_zero, result_valid && (result.verdict != VERDICT_KEPT),
                  (result.cap_len == '0) && (result.pkt_len == '0),
                  "dropped frame carries a length")
  `WCP_ASSERT_IMP(a_kept_len, result_valid && (result.verdict == VERDICT_KEPT),
                  (result.pkt_len != '0) && (result.cap_len <= result.pkt_len),
                  "kept frame lengths inconsistent")
  `WCP_ASSERT_NXT(a_reset_quiet, rst, !result_valid, "result strobe right after reset")

endmodule

bind wlan_capture_prefilter wcp_checker u_wcp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
